FILE: hw/rtl/fct_pkg.sv
// Package: table geometry, entry and request/response types, sequencer states.
package fct_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int AW            = $clog2(TABLE_ENTRIES);
  localparam int SW            = $clog2(TABLE_ENTRIES + 1);
  localparam int SCAN_CAP      = (TABLE_ENTRIES < 256) ? TABLE_ENTRIES : 256;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_END  = 2'd1,
    KIND_RESV = 2'd2,
    KIND_LINK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FUNC_MARK   = 2'd0,
    FUNC_LOCATE = 2'd1,
    FUNC_EXTEND = 2'd2,
    FUNC_FREE   = 2'd3
  } func_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] link;
  } entry_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] target_block;
    logic [1:0] mark_kind;
    logic [7:0] link_target;
    logic [7:0] chain_position;
    logic [8:0] block_count;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] result_block;
    logic       chain_short;
    logic [8:0] blocks_added;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_RD,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/fct_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface fct_req_if;
  logic          valid;
  logic          ready;
  fct_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fct_rsp_if;
  logic          valid;
  logic          ready;
  fct_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/fat_chain_table_engine_core.sv
// Top level: allocation table chain engine with one table memory and a sequencer.
// Steps: mark writes the entry directly; locate/extend/free read the start entry and stop if it
// is not live, then follow links (free clears each entry before reading the next); extend then
// scans for free entries and links each one onto the chain. One request at a time;
// the next is taken once the result is registered. The table has one read and one write port.
// Reset (rst, synchronous): valid bits cleared so the table reads all free, scan_limit 256.
module fat_chain_table_engine_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  fct_req_if.sink    req,
  fct_rsp_if.source  rsp
);
  import fct_pkg::*;

  state_t state, state_next;

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;
  entry_t                   rdata;
  logic                     rvalid;
  entry_t                   ent;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic [8:0] scan_limit;

  req_t          item, item_next;
  logic [AW-1:0] blk, blk_next;
  logic [SW-1:0] steps, steps_next;
  logic [8:0]    idx, idx_next;
  logic [8:0]    added, added_next;
  logic [8:0]    lim, lim_next;
  logic          ok_r, ok_next;
  logic [7:0]    res, res_next;
  logic          shortf, shortf_next;

  logic          rsp_valid;
  rsp_t          rsp_data;

  logic          accept;
  logic          in_range;
  logic          live;
  logic          can_follow;
  logic          walk_go;
  logic [8:0]    idx_inc;
  logic [8:0]    added_inc;
  logic          rsp_free;
  logic [8:0]    lim_req;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_range  = 32'(req.data.target_block) < TABLE_ENTRIES;
  assign ent       = rvalid ? rdata : entry_t'('0);
  assign live      = (ent.kind == KIND_END) || (ent.kind == KIND_LINK);
  assign can_follow = (ent.kind == KIND_LINK) && (32'(ent.link) < TABLE_ENTRIES);
  assign walk_go   = can_follow && (32'(steps) < TABLE_ENTRIES) &&
                     ((item.func != FUNC_LOCATE) || (32'(steps) < 32'(item.chain_position)));
  assign idx_inc   = 9'(idx + 9'd1);
  assign added_inc = 9'(added + 9'd1);
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign lim_req   = (scan_limit > 9'(SCAN_CAP)) ? 9'(SCAN_CAP) : scan_limit;

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // table memory, one read port and one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= 9'd256;
    end else if (cfg_we) begin
      scan_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    item   <= item_next;
    blk    <= blk_next;
    steps  <= steps_next;
    idx    <= idx_next;
    added  <= added_next;
    lim    <= lim_next;
    ok_r   <= ok_next;
    res    <= res_next;
    shortf <= shortf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp_data.ok           <= ok_r;
      rsp_data.result_block <= res;
      rsp_data.chain_short  <= shortf;
      rsp_data.blocks_added <= added;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!in_range || req.data.func == FUNC_MARK) begin
            state_next = S_DONE;
          end else begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        state_next = live ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (walk_go) begin
          state_next = (item.func == FUNC_FREE) ? S_RD : S_WALK;
        end else if (item.func == FUNC_EXTEND && lim != '0 && item.block_count != '0) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RD: begin
        state_next = S_WALK;
      end
      S_SCAN: begin
        if (ent.kind == KIND_FREE) begin
          state_next = S_MARK;
        end else if (idx_inc < lim) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MARK: begin
        state_next = (idx_inc < lim && added_inc < item.block_count) ? S_SCAN : S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = blk;
    wr_en       = 1'b0;
    wr_addr     = blk;
    wr_data     = '0;
    item_next   = item;
    blk_next    = blk;
    steps_next  = steps;
    idx_next    = idx;
    added_next  = added;
    lim_next    = lim;
    ok_next     = ok_r;
    res_next    = res;
    shortf_next = shortf;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          item_next   = req.data;
          blk_next    = AW'(req.data.target_block);
          steps_next  = '0;
          idx_next    = '0;
          added_next  = '0;
          lim_next    = lim_req;
          ok_next     = 1'b0;
          res_next    = '0;
          shortf_next = 1'b0;
          if (in_range) begin
            if (req.data.func == FUNC_MARK) begin
              wr_en        = 1'b1;
              wr_addr      = AW'(req.data.target_block);
              wr_data.kind = kind_t'(req.data.mark_kind);
              wr_data.link = (req.data.mark_kind == KIND_LINK) ? req.data.link_target : 8'd0;
              ok_next      = 1'b1;
            end else begin
              rd_en   = 1'b1;
              rd_addr = AW'(req.data.target_block);
            end
          end
        end
      end
      S_START: begin
        if (live) begin
          ok_next = 1'b1;
          rd_en   = 1'b1;
          rd_addr = blk;
        end
      end
      S_WALK: begin
        if (walk_go) begin
          blk_next   = AW'(ent.link);
          steps_next = SW'(steps + 1'b1);
          if (item.func == FUNC_FREE) begin
            wr_en   = 1'b1;
            wr_addr = blk;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(ent.link);
          end
        end else begin
          unique case (func_t'(item.func))
            FUNC_LOCATE: begin
              res_next    = 8'(blk);
              shortf_next = 32'(steps) < 32'(item.chain_position);
            end
            FUNC_EXTEND: begin
              idx_next = '0;
              rd_en    = 1'b1;
              rd_addr  = '0;
            end
            FUNC_FREE: begin
              wr_en   = live;
              wr_addr = blk;
            end
            FUNC_MARK: begin
            end
          endcase
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = blk;
      end
      S_SCAN: begin
        if (ent.kind == KIND_FREE) begin
          wr_en        = 1'b1;
          wr_addr      = blk;
          wr_data.kind = KIND_LINK;
          wr_data.link = 8'(idx);
        end else begin
          idx_next = idx_inc;
          rd_en    = idx_inc < lim;
          rd_addr  = AW'(idx_inc);
        end
      end
      S_MARK: begin
        wr_en        = 1'b1;
        wr_addr      = AW'(idx);
        wr_data.kind = KIND_END;
        wr_data.link = 8'd0;
        blk_next     = AW'(idx);
        added_next   = added_inc;
        idx_next     = idx_inc;
        rd_en        = idx_inc < lim && added_inc < item.block_count;
        rd_addr      = AW'(idx_inc);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: verif/fat_chain_table_engine_core_tb.sv
// Testbench: directed and random table requests; responses checked against typed values or a chain-walking predictor.
module fat_chain_table_engine_core_tb;
  import fct_pkg::*;

  localparam int IDLE_PCT   = 31;
  localparam int PHASES     = 6;
  localparam int PHASE_REQS = 195;
  localparam int SETTLE_CYC = 1000;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [8:0] cfg_wdata;

  fct_req_if req_ch ();
  fct_rsp_if rsp_ch ();

  entry_t     fat_model [TABLE_ENTRIES];
  logic [8:0] scan_model;
  rsp_t       pending_results [$];
  dir_row_t   directed_rows [$];
  int         errors = 0;
  bit         calm   = 1'b0;

  fat_chain_table_engine_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #4 clk = ~clk;

  function automatic bit follows(input logic [AW-1:0] blk);
    return fat_model[blk].kind == KIND_LINK && int'(fat_model[blk].link) < TABLE_ENTRIES;
  endfunction

  function automatic rsp_t apply_fat_op(input req_t r);
    rsp_t          o;
    logic [AW-1:0] blk;
    logic [AW-1:0] nxt;
    int            steps;
    int            lim;
    int            added;
    o     = '0;
    blk   = r.target_block;
    steps = 0;
    added = 0;
    if (int'(r.target_block) >= TABLE_ENTRIES) begin
      return o;
    end
    if (r.func == FUNC_MARK) begin
      fat_model[blk].kind = kind_t'(r.mark_kind);
      fat_model[blk].link = (r.mark_kind == KIND_LINK) ? r.link_target : 8'd0;
      o.ok = 1'b1;
    end else if (fat_model[blk].kind == KIND_END || fat_model[blk].kind == KIND_LINK) begin
      o.ok = 1'b1;
      case (r.func)
        FUNC_LOCATE: begin
          while (steps < int'(r.chain_position) && steps < TABLE_ENTRIES && follows(blk)) begin
            blk = fat_model[blk].link;
            steps++;
          end
          o.result_block = 8'(blk);
          o.chain_short  = steps < int'(r.chain_position);
        end
        FUNC_EXTEND: begin
          while (steps < TABLE_ENTRIES && follows(blk)) begin
            blk = fat_model[blk].link;
            steps++;
          end
          lim = (int'(scan_model) > SCAN_CAP) ? SCAN_CAP : int'(scan_model);
          for (int i = 0; i < lim && added < int'(r.block_count); i++) begin
            if (fat_model[i].kind == KIND_FREE) begin
              fat_model[blk].kind = KIND_LINK;
              fat_model[blk].link = 8'(i);
              fat_model[i].kind   = KIND_END;
              fat_model[i].link   = 8'd0;
              blk = AW'(i);
              added++;
            end
          end
          o.blocks_added = 9'(added);
        end
        FUNC_FREE: begin
          while (steps < TABLE_ENTRIES && follows(blk)) begin
            nxt = fat_model[blk].link;
            fat_model[blk].kind = KIND_FREE;
            fat_model[blk].link = 8'd0;
            blk = nxt;
            steps++;
          end
          if (fat_model[blk].kind == KIND_END || fat_model[blk].kind == KIND_LINK) begin
            fat_model[blk].kind = KIND_FREE;
            fat_model[blk].link = 8'd0;
          end
        end
        default: begin
        end
      endcase
    end
    return o;
  endfunction

  function automatic dir_row_t dir(input func_t f, input int tgt, input kind_t mk, input int lt,
                                   input int pos, input int cnt, input bit typed, input bit ok,
                                   input int res, input bit sh, input int add);
    dir_row_t d;
    d.req.func           = f;
    d.req.target_block   = 8'(tgt);
    d.req.mark_kind      = mk;
    d.req.link_target    = 8'(lt);
    d.req.chain_position = 8'(pos);
    d.req.block_count    = 9'(cnt);
    d.typed              = typed;
    d.rsp.ok             = ok;
    d.rsp.result_block   = 8'(res);
    d.rsp.chain_short    = sh;
    d.rsp.blocks_added   = 9'(add);
    return d;
  endfunction

  function automatic logic [7:0] pick_chain_start();
    int         base;
    logic [7:0] b;
    base = $urandom_range(TABLE_ENTRIES - 1);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      b = 8'((base + k) % TABLE_ENTRIES);
      if (fat_model[b].kind == KIND_END || fat_model[b].kind == KIND_LINK) begin
        return b;
      end
    end
    return 8'(base);
  endfunction

  function automatic req_t random_request();
    req_t        r;
    logic [63:0] raw;
    int          sel;
    raw = {$urandom, $urandom};
    r   = raw[$bits(req_t)-1:0];
    sel = $urandom_range(99);
    if (sel < 22) begin
      r.func = FUNC_MARK;
      sel = $urandom_range(99);
      r.mark_kind = (sel < 40) ? KIND_END : (sel < 65) ? KIND_LINK :
                    (sel < 75) ? KIND_RESV : KIND_FREE;
      if (r.mark_kind == KIND_LINK && $urandom_range(1) == 1) begin
        r.link_target = pick_chain_start();
      end
    end else begin
      r.func = (sel < 45) ? FUNC_LOCATE : (sel < 75) ? FUNC_EXTEND : FUNC_FREE;
      if ($urandom_range(99) < 85) begin
        r.target_block = pick_chain_start();
      end
      if ($urandom_range(99) < 80) begin
        r.chain_position = 8'($urandom_range(15));
      end
    end
    sel = $urandom_range(99);
    r.block_count = (sel < 70) ? 9'($urandom_range(6)) :
                    (sel < 95) ? 9'($urandom_range(40)) :
                    (sel < 98) ? 9'd256 : 9'($urandom_range(256));
    return r;
  endfunction

  task automatic push_request(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_fat_op(r);
    pending_results.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_scan(input logic [8:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    scan_model = v;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %h", $time, rsp_ch.data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, rsp_ch.data.ok);
        check_field("result_block", want.result_block, rsp_ch.data.result_block);
        check_field("chain_short", want.chain_short, rsp_ch.data.chain_short);
        check_field("blocks_added", want.blocks_added, rsp_ch.data.blocks_added);
      end
    end
  end

  initial begin
    logic [8:0] scan_set [PHASES];
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    foreach (fat_model[i]) begin
      fat_model[i] = '{kind: KIND_FREE, link: 8'd0};
    end
    scan_model = 9'd256;

    // reset table is all free: every walk start before the first mark is refused
    directed_rows.push_back(dir(FUNC_LOCATE, 0, KIND_FREE, 0, 0, 0, 1, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_EXTEND, 255, KIND_FREE, 0, 0, 1, 1, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_FREE, 7, KIND_FREE, 0, 0, 0, 1, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_MARK, 0, KIND_END, 255, 255, 256, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_LOCATE, 0, KIND_FREE, 0, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_LOCATE, 0, KIND_FREE, 0, 255, 0, 1, 1, 0, 1, 0));
    directed_rows.push_back(dir(FUNC_EXTEND, 0, KIND_FREE, 0, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_EXTEND, 0, KIND_FREE, 0, 0, 3, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_LOCATE, 0, KIND_FREE, 0, 2, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_MARK, 10, KIND_RESV, 0, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_EXTEND, 10, KIND_FREE, 0, 0, 1, 1, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_MARK, 255, KIND_LINK, 255, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_LOCATE, 255, KIND_FREE, 0, 255, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_EXTEND, 255, KIND_FREE, 0, 0, 2, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_FREE, 255, KIND_FREE, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_MARK, 20, KIND_LINK, 30, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_FREE, 20, KIND_FREE, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_MARK, 40, KIND_LINK, 41, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_MARK, 41, KIND_RESV, 170, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_FREE, 40, KIND_FREE, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_FREE, 0, KIND_FREE, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_MARK, 5, KIND_END, 0, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_EXTEND, 5, KIND_FREE, 0, 0, 256, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_LOCATE, 5, KIND_FREE, 0, 255, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_FREE, 5, KIND_FREE, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir(FUNC_MARK, 10, KIND_FREE, 170, 0, 0, 1, 1, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      push_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end

    scan_set = '{9'd0, 9'd1, 9'd256, 9'd255, 9'($urandom_range(2, 254)), 9'd128};
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_scan(scan_set[p]);
      calm = (p == 2);
      for (int n = 0; n < PHASE_REQS; n++) begin
        // now and then, hold off until the engine has answered everything
        if ($urandom_range(99) < 2) begin
          drain();
        end
        push_request(random_request(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("fat_chain_table_engine_core_tb: PASS");
    end else begin
      $display("fat_chain_table_engine_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("fat_chain_table_engine_core_tb: FAIL");
    $finish;
  end

endmodule

FILE: fat_chain_table_engine_core.f
hw/rtl/fct_pkg.sv
hw/rtl/fct_if.sv
hw/rtl/fat_chain_table_engine_core.sv
verif/fat_chain_table_engine_core_tb.sv
